// File: rtl/chs_pkg.sv
// ----------------------------------------------------------------------------
// chs_pkg
// Shared constants, codes and controller/datapath interface types of the
// coverage histogram with trusted/excess split.
// ----------------------------------------------------------------------------
package chs_pkg;

  localparam int BINS       = 1024;
  localparam int COUNT_BITS = 32;
  localparam int FRAC_BITS  = 8;

  localparam int BIN_W   = $clog2(BINS);
  localparam int IDX_W   = BIN_W + 1;
  localparam int SUM_W   = COUNT_BITS + BIN_W;
  localparam int WSUM_W  = COUNT_BITS + 2 * BIN_W;
  localparam int Q_W     = BIN_W + FRAC_BITS;
  localparam int CFG_W   = 8;
  localparam int PROD_W  = COUNT_BITS + CFG_W;
  localparam int FREQ_W  = 24;
  localparam int BFULL_W = FREQ_W - FRAC_BITS + 1;
  localparam int HALF    = 1 << (FRAC_BITS - 1);

  localparam int OP_W      = 2;
  localparam int RBIN_W    = 10;
  localparam int OCNT_W    = 32;
  localparam int MEAN_W    = 18;
  localparam int OBIN_W    = 10;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_ANALYZE = 2'd1,
    OP_READ    = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_VALLEY = 2'd1,
    ST_NO_PEAK   = 2'd2,
    ST_CLAMPED   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ASEL_CTRL,
    ASEL_BIN,
    ASEL_IDX
  } asel_t;

  typedef enum logic [1:0] {
    TW_ZERO,
    TW_COPY,
    TW_TRQ,
    TW_MIN
  } tw_t;

  typedef struct packed {
    logic             in_ld;
    asel_t            asel;
    logic [BIN_W-1:0] raddr;
    logic [BIN_W-1:0] waddr;
    logic             real_we;
    logic             real_inc;
    logic             tr_we;
    tw_t              tr_wsel;
    logic             ld_prev;
    logic             ld_thr;
    logic             ld_pk;
    logic             acc_clr;
    logic             acc_en;
    logic [BIN_W-1:0] weight;
    logic             div_start;
    logic             ld_run;
    logic             run_min;
    logic             from_oob;
    logic             commit;
    logic             commit_valley;
    logic [BIN_W-1:0] valley;
    logic [BIN_W-1:0] peak;
    logic             out_ld;
    logic             out_read;
    status_t          status;
  } cmd_t;

  typedef struct packed {
    logic             gt_prev;
    logic             lt_prev;
    logic             prev_gt_thr;
    logic             q_gt_pk;
    logic             div_done;
    logic             clamped;
    logic [BIN_W-1:0] mean_int;
    logic             mean_half;
  } stat_t;

endpackage

// File: rtl/chs_div.sv
// ----------------------------------------------------------------------------
// chs_div
// Restoring divider, one quotient bit per cycle: floor(num * 2^FRAC / den)
// for quotients known to stay below BINS * 2^FRAC.
// ----------------------------------------------------------------------------
module chs_div
  import chs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [WSUM_W-1:0] num,
  input  logic [SUM_W-1:0]  den,
  output logic              done,
  output logic [Q_W-1:0]    quot
);

  localparam int CNT_W = $clog2(Q_W + 1);

  logic [SUM_W-1:0] rem_r;
  logic [SUM_W-1:0] den_r;
  logic [Q_W-1:0]   low_r;
  logic [Q_W-1:0]   q_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic             zero_r;
  logic [SUM_W:0]   trial;
  logic [SUM_W:0]   diff;
  logic             take;

  assign trial = {rem_r, low_r[Q_W-1]};
  assign take  = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        // upper part is below den since the mean lies inside the table
        rem_r  <= num[WSUM_W-1:BIN_W];
        low_r  <= {num[BIN_W-1:0], {FRAC_BITS{1'b0}}};
        den_r  <= den;
        zero_r <= (den == '0);
        q_r    <= '0;
        cnt_r  <= CNT_W'(Q_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= take ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
        q_r   <= {q_r[Q_W-2:0], take};
        low_r <= {low_r[Q_W-2:0], 1'b0};
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = zero_r ? '0 : q_r;

endmodule

// File: rtl/chs_dp.sv
// ----------------------------------------------------------------------------
// chs_dp
// Datapath: real and trusted count memories, scan compare registers, window
// accumulators, mean divider, architectural result registers and output
// register.
// ----------------------------------------------------------------------------
module chs_dp
  import chs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output stat_t              st,
  input  logic [FREQ_W-1:0]  in_frequency,
  input  logic [RBIN_W-1:0]  in_bin_index,
  input  logic [CFG_W-1:0]   peak_factor,
  input  logic [CFG_W-1:0]   border_fraction,
  output logic [1:0]         out_status,
  output logic [OCNT_W-1:0]  out_real_count,
  output logic [OCNT_W-1:0]  out_trusted_count,
  output logic [OCNT_W-1:0]  out_excess_count,
  output logic [MEAN_W-1:0]  out_mean_position,
  output logic [OBIN_W-1:0]  out_valley_bin,
  output logic [OBIN_W-1:0]  out_peak_bin
);

  logic [COUNT_BITS-1:0] real_mem [BINS];
  logic [COUNT_BITS-1:0] tr_mem [BINS];

  logic [COUNT_BITS-1:0] real_q_r;
  logic [COUNT_BITS-1:0] tr_q_r;
  logic [BIN_W-1:0]      bin_r;
  logic                  clamp_r;
  logic [RBIN_W-1:0]     idx_r;
  logic [COUNT_BITS-1:0] prev_r;
  logic [PROD_W-1:0]     thr_r;
  logic [PROD_W-1:0]     pk_r;
  logic [SUM_W-1:0]      mass_r;
  logic [WSUM_W-1:0]     wsum_r;
  logic [COUNT_BITS-1:0] run_r;
  logic [MEAN_W-1:0]     mean_reg_r;
  logic [BIN_W-1:0]      valley_reg_r;
  logic [BIN_W-1:0]      peak_reg_r;

  logic [FREQ_W:0]       rnd;
  logic [BFULL_W-1:0]    bin_full;
  logic                  clamp;
  logic [BIN_W-1:0]      raddr;
  logic [BIN_W-1:0]      waddr;
  logic [COUNT_BITS-1:0] real_wd;
  logic [COUNT_BITS-1:0] tr_wd;
  logic [COUNT_BITS-1:0] from_val;
  logic [COUNT_BITS-1:0] min_val;
  logic [SUM_W-1:0]      wprod;
  logic                  idx_ok;
  logic                  div_done;
  logic [Q_W-1:0]        quot;

  // nearest bin of the sample, clamped below the last bin
  assign rnd      = {1'b0, in_frequency} + (FREQ_W + 1)'(HALF);
  assign bin_full = rnd[FREQ_W -: BFULL_W];
  assign clamp    = bin_full > BFULL_W'(BINS - 2);
  assign idx_ok   = 32'(idx_r) < BINS;

  always_comb begin
    unique case (cmd.asel)
      ASEL_BIN: begin
        raddr = bin_r;
        waddr = bin_r;
      end
      ASEL_IDX: begin
        raddr = BIN_W'(idx_r);
        waddr = cmd.waddr;
      end
      default: begin
        raddr = cmd.raddr;
        waddr = cmd.waddr;
      end
    endcase
  end

  assign from_val = cmd.from_oob ? '0 : tr_q_r;
  assign min_val  = (run_r < from_val) ? run_r : from_val;

  always_comb begin
    if (!cmd.real_inc) begin
      real_wd = '0;
    end else if (real_q_r == '1) begin
      real_wd = real_q_r;
    end else begin
      real_wd = real_q_r + COUNT_BITS'(1);
    end
  end

  always_comb begin
    case (cmd.tr_wsel)
      TW_COPY: tr_wd = real_q_r;
      TW_TRQ:  tr_wd = tr_q_r;
      TW_MIN:  tr_wd = min_val;
      default: tr_wd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.real_we) begin
      real_mem[waddr] <= real_wd;
    end
    real_q_r <= real_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.tr_we) begin
      tr_mem[waddr] <= tr_wd;
    end
    tr_q_r <= tr_mem[raddr];
  end

  assign wprod = SUM_W'(real_q_r) * SUM_W'(cmd.weight);

  always_ff @(posedge clk) begin
    if (cmd.in_ld) begin
      bin_r   <= clamp ? BIN_W'(BINS - 2) : bin_full[BIN_W-1:0];
      clamp_r <= clamp;
      idx_r   <= in_bin_index;
    end
    if (cmd.ld_prev) begin
      prev_r <= real_q_r;
    end
    if (cmd.ld_thr) begin
      thr_r <= PROD_W'(prev_r) * PROD_W'(peak_factor);
    end
    if (cmd.ld_pk) begin
      pk_r <= PROD_W'(prev_r) * PROD_W'(border_fraction);
    end
    if (cmd.acc_clr) begin
      mass_r <= '0;
      wsum_r <= '0;
    end else if (cmd.acc_en) begin
      mass_r <= mass_r + SUM_W'(real_q_r);
      wsum_r <= wsum_r + WSUM_W'(wprod);
    end
    if (cmd.ld_run) begin
      run_r <= tr_q_r;
    end else if (cmd.run_min) begin
      run_r <= min_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_reg_r   <= '0;
      valley_reg_r <= '0;
      peak_reg_r   <= '0;
    end else begin
      if (cmd.commit) begin
        mean_reg_r   <= MEAN_W'(quot);
        valley_reg_r <= cmd.valley;
        peak_reg_r   <= cmd.peak;
      end else if (cmd.commit_valley) begin
        valley_reg_r <= cmd.valley;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_status        <= cmd.status;
      out_mean_position <= mean_reg_r;
      out_valley_bin    <= OBIN_W'(valley_reg_r);
      out_peak_bin      <= OBIN_W'(peak_reg_r);
      if (cmd.out_read && idx_ok) begin
        out_real_count    <= OCNT_W'(real_q_r);
        out_trusted_count <= OCNT_W'(tr_q_r);
        out_excess_count  <= (real_q_r > tr_q_r) ? OCNT_W'(real_q_r - tr_q_r) : '0;
      end else begin
        out_real_count    <= '0;
        out_trusted_count <= '0;
        out_excess_count  <= '0;
      end
    end
  end

  chs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (wsum_r),
    .den   (mass_r),
    .done  (div_done),
    .quot  (quot)
  );

  assign st.gt_prev     = real_q_r > prev_r;
  assign st.lt_prev     = real_q_r < prev_r;
  assign st.prev_gt_thr = PROD_W'(prev_r) > thr_r;
  assign st.q_gt_pk     = {real_q_r, {CFG_W{1'b0}}} > pk_r;
  assign st.div_done    = div_done;
  assign st.clamped     = clamp_r;
  assign st.mean_int    = quot[Q_W-1:FRAC_BITS];
  assign st.mean_half   = quot[FRAC_BITS-1];

endmodule

// File: rtl/chs_ctrl.sv
// ----------------------------------------------------------------------------
// chs_ctrl
// Controller: clearing pass, request decode, valley/peak/border scans, window
// sum, copy and mirror sequencing, and the output handshake.
// ----------------------------------------------------------------------------
module chs_ctrl
  import chs_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [OP_W-1:0] in_opcode,
  output logic            out_valid,
  input  logic            out_ready,
  output cmd_t            cmd,
  input  stat_t           st
);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_ADD_RD, S_ADD_WR, S_RD_WAIT,
    S_V_FIRST, S_V_LOAD, S_V_ISS, S_V_CHK, S_P_ISS, S_P_CHK,
    S_L_ISS, S_L_CHK, S_R_ISS, S_R_CHK, S_W_ISS, S_W_CHK,
    S_DIV, S_DIV_WAIT, S_C_ISS, S_C_WR,
    S_M0_ISS, S_M0_CHK, S_M_ISS, S_M_CHK, S_PUB
  } state_t;

  state_t           state_r;
  op_t              op_r;
  status_t          status_r;
  logic [IDX_W-1:0] cnt_r;
  logic [IDX_W-1:0] lb_r;
  logic [IDX_W-1:0] rb_r;
  logic [BIN_W-1:0] valley_r;
  logic [BIN_W-1:0] peak_r;
  logic             out_valid_r;

  logic             half_ok;
  logic [IDX_W-1:0] mean_a;
  logic [IDX_W-1:0] from;
  logic             found_peak;
  logic             pub_go;

  assign mean_a     = IDX_W'(st.mean_int);
  // round the mirror point up only if a bin to the right exists
  assign half_ok    = st.mean_half && (st.mean_int != BIN_W'(BINS - 1));
  assign from       = mean_a + cnt_r + IDX_W'(st.mean_half);
  assign found_peak = st.lt_prev && st.prev_gt_thr;
  assign pub_go     = !out_valid_r || out_ready;

  always_comb begin
    cmd        = '0;
    cmd.valley = valley_r;
    cmd.peak   = peak_r;
    cmd.status = status_r;
    in_ready   = 1'b0;
    case (op_r)
      OP_ADD:  cmd.asel = ASEL_BIN;
      OP_READ: cmd.asel = ASEL_IDX;
      default: cmd.asel = ASEL_CTRL;
    endcase
    unique case (state_r)
      S_CLEAR: begin
        cmd.waddr   = cnt_r[BIN_W-1:0];
        cmd.real_we = 1'b1;
        cmd.tr_we   = 1'b1;
        cmd.tr_wsel = TW_ZERO;
      end
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.in_ld = in_valid;
      end
      S_ADD_WR: begin
        cmd.real_we  = 1'b1;
        cmd.real_inc = 1'b1;
      end
      S_V_FIRST: cmd.raddr = BIN_W'(1);
      S_V_LOAD:  cmd.ld_prev = 1'b1;
      S_V_ISS:   cmd.raddr = BIN_W'(cnt_r + IDX_W'(1));
      S_V_CHK: begin
        cmd.ld_thr  = st.gt_prev;
        cmd.ld_prev = !st.gt_prev;
      end
      S_P_ISS: cmd.raddr = BIN_W'(cnt_r + IDX_W'(1));
      S_P_CHK: begin
        cmd.ld_pk         = found_peak;
        cmd.ld_prev       = !found_peak;
        cmd.commit_valley = !found_peak && (cnt_r >= IDX_W'(BINS - 2));
      end
      S_L_ISS: begin
        cmd.raddr   = cnt_r[BIN_W-1:0];
        cmd.acc_clr = 1'b1;
      end
      S_R_ISS: cmd.raddr = cnt_r[BIN_W-1:0];
      S_W_ISS: cmd.raddr = cnt_r[BIN_W-1:0];
      S_W_CHK: begin
        cmd.acc_en = 1'b1;
        cmd.weight = cnt_r[BIN_W-1:0];
      end
      S_DIV:   cmd.div_start = 1'b1;
      S_C_ISS: cmd.raddr = cnt_r[BIN_W-1:0];
      S_C_WR: begin
        cmd.waddr   = cnt_r[BIN_W-1:0];
        cmd.tr_we   = 1'b1;
        cmd.tr_wsel = TW_COPY;
      end
      S_M0_ISS: cmd.raddr = BIN_W'(mean_a + IDX_W'(half_ok));
      S_M0_CHK: begin
        cmd.ld_run  = 1'b1;
        cmd.waddr   = st.mean_int;
        cmd.tr_we   = half_ok;
        cmd.tr_wsel = TW_TRQ;
        cmd.commit  = (mean_a == '0);
      end
      S_M_ISS: cmd.raddr = from[BIN_W-1:0];
      S_M_CHK: begin
        cmd.run_min  = 1'b1;
        cmd.from_oob = from >= IDX_W'(BINS);
        cmd.waddr    = BIN_W'(mean_a - cnt_r);
        cmd.tr_we    = 1'b1;
        cmd.tr_wsel  = TW_MIN;
        cmd.commit   = (cnt_r == mean_a);
      end
      S_PUB: begin
        cmd.out_ld   = pub_go;
        cmd.out_read = (op_r == OP_READ);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      op_r        <= OP_NONE;
      status_r    <= ST_OK;
      cnt_r       <= '0;
      lb_r        <= '0;
      rb_r        <= '0;
      valley_r    <= '0;
      peak_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          cnt_r <= cnt_r + IDX_W'(1);
          if (cnt_r == IDX_W'(BINS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            op_r     <= op_t'(in_opcode);
            status_r <= ST_OK;
            unique case (op_t'(in_opcode))
              OP_ADD:     state_r <= S_ADD_RD;
              OP_ANALYZE: state_r <= S_V_FIRST;
              OP_READ:    state_r <= S_RD_WAIT;
              default:    state_r <= S_PUB;
            endcase
          end
        end
        S_ADD_RD: state_r <= S_ADD_WR;
        S_ADD_WR: begin
          status_r <= st.clamped ? ST_CLAMPED : ST_OK;
          state_r  <= S_PUB;
        end
        S_RD_WAIT: state_r <= S_PUB;
        S_V_FIRST: begin
          cnt_r   <= IDX_W'(1);
          state_r <= S_V_LOAD;
        end
        S_V_LOAD: state_r <= S_V_ISS;
        S_V_ISS:  state_r <= S_V_CHK;
        S_V_CHK: begin
          if (st.gt_prev) begin
            valley_r <= cnt_r[BIN_W-1:0];
            state_r  <= S_P_ISS;
          end else if (cnt_r < IDX_W'(BINS - 2)) begin
            cnt_r   <= cnt_r + IDX_W'(1);
            state_r <= S_V_ISS;
          end else begin
            status_r <= ST_NO_VALLEY;
            state_r  <= S_PUB;
          end
        end
        S_P_ISS: state_r <= S_P_CHK;
        S_P_CHK: begin
          if (found_peak) begin
            peak_r  <= cnt_r[BIN_W-1:0];
            state_r <= S_L_ISS;
          end else if (cnt_r < IDX_W'(BINS - 2)) begin
            cnt_r   <= cnt_r + IDX_W'(1);
            state_r <= S_P_ISS;
          end else begin
            status_r <= ST_NO_PEAK;
            state_r  <= S_PUB;
          end
        end
        S_L_ISS: state_r <= S_L_CHK;
        S_L_CHK: begin
          if (cnt_r != '0 && st.q_gt_pk) begin
            cnt_r   <= cnt_r - IDX_W'(1);
            state_r <= S_L_ISS;
          end else begin
            lb_r    <= cnt_r;
            cnt_r   <= IDX_W'(peak_r);
            state_r <= S_R_ISS;
          end
        end
        S_R_ISS: state_r <= S_R_CHK;
        S_R_CHK: begin
          if (cnt_r < IDX_W'(BINS - 1) && st.q_gt_pk) begin
            cnt_r   <= cnt_r + IDX_W'(1);
            state_r <= S_R_ISS;
          end else begin
            rb_r    <= cnt_r;
            cnt_r   <= lb_r;
            state_r <= S_W_ISS;
          end
        end
        S_W_ISS: state_r <= S_W_CHK;
        S_W_CHK: begin
          if (cnt_r == rb_r) begin
            state_r <= S_DIV;
          end else begin
            cnt_r   <= cnt_r + IDX_W'(1);
            state_r <= S_W_ISS;
          end
        end
        S_DIV: state_r <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (st.div_done) begin
            cnt_r   <= '0;
            state_r <= S_C_ISS;
          end
        end
        S_C_ISS: state_r <= S_C_WR;
        S_C_WR: begin
          if (cnt_r == IDX_W'(BINS - 1)) begin
            state_r <= S_M0_ISS;
          end else begin
            cnt_r   <= cnt_r + IDX_W'(1);
            state_r <= S_C_ISS;
          end
        end
        S_M0_ISS: state_r <= S_M0_CHK;
        S_M0_CHK: begin
          if (mean_a == '0) begin
            status_r <= ST_OK;
            state_r  <= S_PUB;
          end else begin
            cnt_r   <= IDX_W'(1);
            state_r <= S_M_ISS;
          end
        end
        S_M_ISS: state_r <= S_M_CHK;
        S_M_CHK: begin
          if (cnt_r == mean_a) begin
            status_r <= ST_OK;
            state_r  <= S_PUB;
          end else begin
            cnt_r   <= cnt_r + IDX_W'(1);
            state_r <= S_M_ISS;
          end
        end
        S_PUB: begin
          if (pub_go) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: rtl/coverage_histogram_trust_split_top.sv
// ----------------------------------------------------------------------------
// coverage_histogram_trust_split_top
// Coverage histogram with trusted/excess split: sample add, analysis, bin read.
// ----------------------------------------------------------------------------
// One request is in flight at a time; its result sits in an output register
// so the next request is taken while that result waits. After reset a
// clearing pass zeroes both 1024-entry count memories before the first
// request is taken. Each memory access has an issue state and a compare
// state. An analysis that finds a peak scans for valley and peak, checks
// the borders, sums the window, runs the divider, copies the trusted table
// and mirrors it; one that finds no valley or no peak stops after its scan.
// Each memory has a single read port.
// ----------------------------------------------------------------------------
module coverage_histogram_trust_split_top
  import chs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [OP_W-1:0]    in_opcode,
  input  logic [FREQ_W-1:0]  in_frequency,
  input  logic [RBIN_W-1:0]  in_bin_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic [OCNT_W-1:0]  out_real_count,
  output logic [OCNT_W-1:0]  out_trusted_count,
  output logic [OCNT_W-1:0]  out_excess_count,
  output logic [MEAN_W-1:0]  out_mean_position,
  output logic [OBIN_W-1:0]  out_valley_bin,
  output logic [OBIN_W-1:0]  out_peak_bin,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [PADDR_W-1:0] cfg_paddr,
  input  logic [PDATA_W-1:0] cfg_pwdata,
  output logic [PDATA_W-1:0] cfg_prdata,
  output logic               cfg_pready
);

  localparam logic REG_PEAK_FACTOR     = 1'b0;
  localparam logic REG_BORDER_FRACTION = 1'b1;

  logic [CFG_W-1:0] peak_factor_r;
  logic [CFG_W-1:0] border_fraction_r;
  logic             cfg_wr;
  cmd_t             cmd;
  stat_t            st;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_factor_r     <= CFG_W'(2);
      border_fraction_r <= CFG_W'(128);
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_PEAK_FACTOR:     peak_factor_r     <= cfg_pwdata[CFG_W-1:0];
        REG_BORDER_FRACTION: border_fraction_r <= cfg_pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_PEAK_FACTOR:     cfg_prdata = PDATA_W'(peak_factor_r);
      REG_BORDER_FRACTION: cfg_prdata = PDATA_W'(border_fraction_r);
      default:             cfg_prdata = '0;
    endcase
  end

  chs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_opcode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .st        (st)
  );

  chs_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .st                (st),
    .in_frequency      (in_frequency),
    .in_bin_index      (in_bin_index),
    .peak_factor       (peak_factor_r),
    .border_fraction   (border_fraction_r),
    .out_status        (out_status),
    .out_real_count    (out_real_count),
    .out_trusted_count (out_trusted_count),
    .out_excess_count  (out_excess_count),
    .out_mean_position (out_mean_position),
    .out_valley_bin    (out_valley_bin),
    .out_peak_bin      (out_peak_bin)
  );

`ifndef SYNTHESIS
  // one request at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in flight");

  // clearing pass runs right after reset
  a_clear_first: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !in_ready)
    else $error("request taken during clearing pass");

  // a result appears only from the publish step, never while idle
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result raised outside publish");
`endif

endmodule

// File: dv/tb_coverage_histogram_trust_split_top.sv
// ----------------------------------------------------------------------------
// tb_coverage_histogram_trust_split_top
// Self-checking bench for the coverage histogram block. Requests are checked
// against an in-bench histogram predictor: sample adds, valley/peak analysis
// with trusted table rebuild, and bin reads, under several threshold
// settings, random idling on both channels and a long result stall.
// ----------------------------------------------------------------------------
module tb_coverage_histogram_trust_split_top;
  import chs_pkg::*;

  localparam logic [PADDR_W-1:0] REG_PEAK_FACTOR = 3'd0;
  localparam logic [PADDR_W-1:0] REG_BORDER_FRAC = 3'd4;
  localparam int WATCHDOG_LIMIT = 40000;
  localparam int LONG_HOLD      = 300;
  localparam logic [63:0] CNT_SAT  = 64'hFFFF_FFFF;
  localparam logic [63:0] MEAN_SAT = 64'h3FFFF;

  typedef struct packed {
    status_t           status;
    logic [OCNT_W-1:0] real_count;
    logic [OCNT_W-1:0] trusted_count;
    logic [OCNT_W-1:0] excess_count;
    logic [MEAN_W-1:0] mean_position;
    logic [OBIN_W-1:0] valley_bin;
    logic [OBIN_W-1:0] peak_bin;
  } bin_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [OP_W-1:0]    in_opcode = '0;
  logic [FREQ_W-1:0]  in_frequency = '0;
  logic [RBIN_W-1:0]  in_bin_index = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         out_status;
  logic [OCNT_W-1:0]  out_real_count;
  logic [OCNT_W-1:0]  out_trusted_count;
  logic [OCNT_W-1:0]  out_excess_count;
  logic [MEAN_W-1:0]  out_mean_position;
  logic [OBIN_W-1:0]  out_valley_bin;
  logic [OBIN_W-1:0]  out_peak_bin;
  logic               cfg_psel = 1'b0;
  logic               cfg_penable = 1'b0;
  logic               cfg_pwrite = 1'b0;
  logic [PADDR_W-1:0] cfg_paddr = '0;
  logic [PDATA_W-1:0] cfg_pwdata = '0;
  logic [PDATA_W-1:0] cfg_prdata;
  logic               cfg_pready;

  coverage_histogram_trust_split_top uut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic [63:0] hist_real [BINS];
  logic [63:0] hist_trusted [BINS];
  logic [63:0] mean_q, valley_q, peak_q, peak_factor_q, border_frac_q;

  bin_result_t pending_q[$];
  int mismatches = 0;
  int send_idle = 0;
  int recv_stall = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  function automatic status_t analyze_hist();
    int unsigned i, valley, peak, lb, rb, dst, src;
    bit found;
    logic [63:0] mass, wmass, ipart, frac, pk, val, m, r;
    found = 0;
    valley = 0;
    peak = 0;
    for (i = 1; i + 1 < BINS; i++) begin
      if (hist_real[i+1] > hist_real[i]) begin
        valley = i;
        found = 1;
        break;
      end
    end
    if (!found) return ST_NO_VALLEY;
    found = 0;
    for (i = valley; i + 1 < BINS; i++) begin
      if (hist_real[i+1] < hist_real[i] &&
          hist_real[i] > hist_real[valley] * peak_factor_q) begin
        peak = i;
        found = 1;
        break;
      end
    end
    if (!found) begin
      valley_q = 64'(valley);
      return ST_NO_PEAK;
    end
    pk = hist_real[peak] * border_frac_q;
    lb = peak;
    rb = peak;
    while (lb > 0 && hist_real[lb] * 256 > pk) lb--;
    while (rb < BINS - 1 && hist_real[rb] * 256 > pk) rb++;
    mass = 0;
    wmass = 0;
    for (i = lb; i <= rb; i++) begin
      mass += hist_real[i];
      wmass += hist_real[i] * 64'(i);
    end
    ipart = 0;
    frac = 0;
    if (mass != 0) begin
      ipart = wmass / mass;
      r = wmass % mass;
      for (int k = 0; k < FRAC_BITS; k++) begin
        frac = frac << 1;
        if (r >= mass - r) begin
          r = r - (mass - r);
          frac |= 1;
        end else begin
          r = r + r;
        end
      end
    end
    if (ipart >= BINS) ipart = 64'(BINS - 1);
    for (i = 0; i < BINS; i++) hist_trusted[i] = hist_real[i];
    // mirror right side onto left with running minimum
    for (i = 0; i <= ipart; i++) begin
      dst = 32'(ipart - 64'(i));
      src = 32'(ipart + 64'(i) + ((frac >= HALF) ? 64'd1 : 64'd0));
      if (dst == src || dst + 1 >= BINS) continue;
      val = (src < BINS) ? hist_trusted[src] : 64'd0;
      hist_trusted[dst] = (hist_trusted[dst+1] < val) ? hist_trusted[dst+1] : val;
    end
    m = (ipart << FRAC_BITS) | frac;
    mean_q = (m > MEAN_SAT) ? MEAN_SAT : m;
    valley_q = 64'(valley);
    peak_q = 64'(peak);
    return ST_OK;
  endfunction

  function automatic bin_result_t predict_request(logic [OP_W-1:0] op,
                                                  logic [FREQ_W-1:0] freq,
                                                  logic [RBIN_W-1:0] idx);
    bin_result_t res;
    logic [63:0] bin;
    res = '0;
    res.status = ST_OK;
    case (op_t'(op))
      OP_ADD: begin
        bin = (64'(freq) + HALF) >> FRAC_BITS;
        if (bin > BINS - 2) begin
          bin = 64'(BINS - 2);
          res.status = ST_CLAMPED;
        end
        if (hist_real[bin] < CNT_SAT) hist_real[bin]++;
      end
      OP_ANALYZE: res.status = analyze_hist();
      OP_READ: begin
        res.real_count = OCNT_W'(hist_real[idx]);
        res.trusted_count = OCNT_W'(hist_trusted[idx]);
        res.excess_count = (hist_real[idx] > hist_trusted[idx]) ?
                           OCNT_W'(hist_real[idx] - hist_trusted[idx]) : '0;
      end
      default: ;
    endcase
    res.mean_position = MEAN_W'(mean_q);
    res.valley_bin = OBIN_W'(valley_q);
    res.peak_bin = OBIN_W'(peak_q);
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      pending_q.push_back(predict_request(in_opcode, in_frequency, in_bin_index));
    end
  end

  always @(posedge clk) begin
    bin_result_t exp_r, got_r;
    if (rst_n && out_valid && out_ready) begin
      got_r = {status_t'(out_status), out_real_count, out_trusted_count,
               out_excess_count, out_mean_position, out_valley_bin, out_peak_bin};
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %p", got_r);
      end else begin
        exp_r = pending_q.pop_front();
        if (got_r !== exp_r) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: exp %p got %p", exp_r, got_r);
        end
      end
    end
  end

  // result side back-pressure, with a long hold on request
  always @(posedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[coverage_histogram_trust_split_top] ERROR");
      $finish;
    end
  end

  task automatic send_req(input op_t op, input logic [FREQ_W-1:0] freq,
                          input logic [RBIN_W-1:0] idx);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_frequency <= freq;
    in_bin_index <= idx;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [7:0] value);
    drain();
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= {24'(0), value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (addr == REG_PEAK_FACTOR) peak_factor_q = 64'(value);
    else border_frac_q = 64'(value);
    @(posedge clk);
  endtask

  task automatic add_bin(input int bin);
    send_req(OP_ADD, FREQ_W'((bin << FRAC_BITS) + $urandom_range(HALF - 1)), '0);
  endtask

  // one clustered distribution, analyzed and read back around its center and at random bins
  task automatic shaped_cluster();
    int center, spread, n;
    center = $urandom_range(BINS - 40, 20);
    spread = $urandom_range(12, 1);
    n = $urandom_range(40, 10);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(9) == 0) begin
        send_req(op_t'($urandom_range(3)), FREQ_W'($urandom), RBIN_W'($urandom));
      end else begin
        add_bin(center + $urandom_range(spread) - $urandom_range(spread));
      end
    end
    send_req(OP_ANALYZE, FREQ_W'($urandom), RBIN_W'($urandom));
    for (int k = 0; k < 6; k++) begin
      if ($urandom_range(2) == 0) send_req(OP_READ, '0, RBIN_W'($urandom));
      else send_req(OP_READ, '0, RBIN_W'(center + $urandom_range(30) - 15));
    end
  endtask

  task automatic test_directed();
    write_reg(REG_PEAK_FACTOR, 8'd255);
    send_req(OP_ANALYZE, '0, '0);            // empty table: no valley
    send_req(OP_NONE, 24'hFFFFFF, 10'h3FF);
    add_bin(1);
    add_bin(2);
    add_bin(2);
    send_req(OP_ANALYZE, '0, '0);            // rise too shallow: no peak
    send_req(OP_ADD, 24'h0, '0);
    send_req(OP_ADD, 24'h7F, '0);
    send_req(OP_ADD, 24'h80, '0);
    send_req(OP_ADD, 24'hFFFFFF, '0);        // beyond the table
    send_req(OP_ADD, FREQ_W'((1022 << FRAC_BITS) + 127), '0);
    send_req(OP_ADD, FREQ_W'((1022 << FRAC_BITS) + 128), '0);
    write_reg(REG_PEAK_FACTOR, 8'd0);
    write_reg(REG_BORDER_FRAC, 8'd0);        // window grows until an empty bin or a table end
    send_req(OP_ANALYZE, '0, '0);
    send_req(OP_READ, '0, 10'd0);
    send_req(OP_READ, '0, 10'd1);
    send_req(OP_READ, '0, 10'd2);
    send_req(OP_READ, '0, 10'd1022);
    send_req(OP_READ, '0, 10'd1023);
    write_reg(REG_BORDER_FRAC, 8'd255);
    send_req(OP_ANALYZE, '0, '0);
    send_req(OP_READ, '0, 10'd1);
  endtask

  task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                   input logic [7:0] pf, input logic [7:0] bf,
                                   input int count);
    write_reg(REG_PEAK_FACTOR, pf);
    write_reg(REG_BORDER_FRAC, bf);
    send_idle = idle_pct;
    recv_stall = stall_pct;
    for (int k = 0; k < count; k++) shaped_cluster();
    drain();
  endtask

  task automatic test_long_stall();
    send_idle = 0;
    recv_stall = 0;
    hold_reqs++;
    for (int k = 0; k < 20; k++) add_bin($urandom_range(200, 100));
    send_req(OP_ANALYZE, '0, '0);
    for (int k = 0; k < 10; k++) send_req(OP_READ, '0, RBIN_W'($urandom_range(220, 80)));
    drain();
  endtask

  initial begin
    for (int i = 0; i < BINS; i++) begin
      hist_real[i] = 0;
      hist_trusted[i] = 0;
    end
    mean_q = 0;
    valley_q = 0;
    peak_q = 0;
    peak_factor_q = 2;
    border_frac_q = 128;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_phase(0, 0, 8'd2, 8'd128, 4);
    test_random_phase(63, 0, 8'd1, 8'd64, 4);
    test_random_phase(0, 63, 8'd255, 8'd255, 3);
    test_random_phase(7, 7, 8'd0, 8'd0, 3);
    test_long_stall();
    test_random_phase(0, 0, 8'd3, 8'd200, 3);
    if (mismatches == 0) begin
      $display("[coverage_histogram_trust_split_top] OK");
    end else begin
      $display("[coverage_histogram_trust_split_top] ERROR");
    end
    $finish;
  end

endmodule
